>>> rtl/core/sliding_window_bollinger_bands_assert.svh
// Assertion macros shared by the Bollinger band core modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SLIDING_WINDOW_BOLLINGER_BANDS_ASSERT_SVH
`define SLIDING_WINDOW_BOLLINGER_BANDS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SWBB_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swbb: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SWBB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swbb: assertion failed");

`endif

>>> rtl/core/swbb_pkg.sv
// Shared types and constants of the Bollinger band core.
// Depends on nothing; the front end, back end and top level import it.
package swbb_pkg;

  localparam int WINDOW_MAX_DEF = 256;

  localparam int PRICE_W = 24;
  localparam int LEN_W   = 9;
  localparam int K_W     = 12;
  localparam int VAR_W   = 48;
  localparam int DEV_W   = 24;
  localparam int SPR_W   = K_W + DEV_W - 8;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH    = 1'd1;

  localparam logic [LEN_W-1:0] LEN_RESET = 9'd20;
  localparam logic [K_W-1:0]   K_RESET   = 12'd512;

  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [PRICE_W-1:0] middle;
    logic [PRICE_W-1:0] upper;
    logic [PRICE_W-1:0] lower;
  } result_t;

endpackage

>>> rtl/core/swbb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module swbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/swbb_fifo.sv
// Small register queue used between the front and back and at the result side.
// Depends on nothing.
module swbb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/core/swbb_front.sv
// Front end: takes price words, maintains the sample ring and the running sums,
// and queues a job once the window is full. Depends on swbb_pkg, swbb_ram and the assertion header.
`include "sliding_window_bollinger_bands_assert.svh"

module swbb_front import swbb_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]           n,
  input  logic                                      clear_window,
  input  logic                                      push,
  input  logic [PRICE_W-1:0]                        price,
  input  logic                                      series_start,
  output logic                                      ready,
  input  logic                                      job_full,
  output logic                                      job_push,
  output logic [PRICE_W+$clog2(WINDOW_MAX)-1:0]     job_sum,
  output logic [2*PRICE_W+$clog2(WINDOW_MAX)-1:0]   job_sumsq
);

  localparam int AW    = $clog2(WINDOW_MAX);
  localparam int NW    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = PRICE_W + AW;
  localparam int SQ_W  = 2 * PRICE_W + AW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]           state;
  logic [AW-1:0]        wp;
  logic [NW-1:0]        fill;
  logic [SUM_W-1:0]     sum;
  logic [SQ_W-1:0]      sumsq;
  logic [PRICE_W-1:0]   price_r;
  logic [2*PRICE_W-1:0] price_sq;
  logic [PRICE_W-1:0]   old;
  logic [2*PRICE_W-1:0] old_sq;
  logic [PRICE_W-1:0]   rd_data;
  logic                 accept;

  assign ready     = (state == ST_IDLE) && !job_full;
  assign accept    = push && ready;
  assign job_push  = (state == ST_PUSH) && (fill >= n);
  assign job_sum   = sum;
  assign job_sumsq = sumsq;

  // A series start restarts the ring at entry zero, so the read follows it.
  swbb_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state == ST_UPD),
    .wr_addr (wp),
    .wr_data (price_r),
    .rd_en   (accept),
    .rd_addr (series_start ? '0 : wp),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wp    <= '0;
      fill  <= '0;
      sum   <= '0;
      sumsq <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (clear_window || (accept && series_start)) begin
            wp    <= '0;
            fill  <= '0;
            sum   <= '0;
            sumsq <= '0;
          end
          if (accept) begin
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          // The oldest sample leaves the sums only once the window is full.
          if (fill >= n) begin
            sum   <= sum - SUM_W'(old) + SUM_W'(price_r);
            sumsq <= sumsq - SQ_W'(old_sq) + SQ_W'(price_sq);
          end else begin
            fill  <= fill + 1'b1;
            sum   <= sum + SUM_W'(price_r);
            sumsq <= sumsq + SQ_W'(price_sq);
          end
          if (32'(wp) + 32'd1 >= 32'(n)) begin
            wp <= '0;
          end else begin
            wp <= wp + 1'b1;
          end
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      price_r  <= price;
      price_sq <= (2*PRICE_W)'(price) * (2*PRICE_W)'(price);
    end
    if (state == ST_SQ) begin
      old    <= rd_data;
      old_sq <= (2*PRICE_W)'(rd_data) * (2*PRICE_W)'(rd_data);
    end
  end

  `SWBB_ASSERT_IMPL(a_wp_in_window, state == ST_IDLE, 32'(wp) < 32'(n))
  `SWBB_ASSERT_IMPL(a_fill_bounded, state == ST_IDLE, fill <= n)
  `SWBB_ASSERT_NEXT(a_accept_starts, accept, state == ST_SQ)

endmodule

>>> rtl/core/swbb_back.sv
// Back end: turns a window job into mean, deviation and the three bands with
// a shared shift-and-subtract sequencer. Depends on swbb_pkg and the assertion header.
`include "sliding_window_bollinger_bands_assert.svh"

module swbb_back import swbb_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      job_valid,
  output logic                                      job_pop,
  input  logic [PRICE_W+$clog2(WINDOW_MAX)-1:0]     job_sum,
  input  logic [2*PRICE_W+$clog2(WINDOW_MAX)-1:0]   job_sumsq,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]           job_n,
  input  logic [2*$clog2(WINDOW_MAX+1)-1:0]         job_nsq,
  input  logic [K_W-1:0]                            job_k,
  input  logic                                      out_full,
  output logic                                      out_push,
  output result_t                                   out_data
);

  localparam int AW    = $clog2(WINDOW_MAX);
  localparam int NW    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = PRICE_W + AW;
  localparam int SQ_W  = 2 * PRICE_W + AW;
  localparam int NUM_W = NW + SQ_W;
  localparam int DR_W  = 2 * NW;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int PR_W  = K_W + DEV_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PH1  = 3'd1;
  localparam logic [2:0] ST_SUB  = 3'd2;
  localparam logic [2:0] ST_PH2  = 3'd3;
  localparam logic [2:0] ST_PH3  = 3'd4;
  localparam logic [2:0] ST_SPR  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]         state;
  logic [CNT_W-1:0]   cnt;
  logic [SUM_W-1:0]   sum_r;
  logic [NW-1:0]      n_r;
  logic [DR_W-1:0]    nsq_r;
  logic [K_W-1:0]     k_r;
  logic [SUM_W-1:0]   mq;
  logic [NW-1:0]      mrem;
  logic [2*SUM_W-1:0] acc2;
  logic [NUM_W-1:0]   accn;
  logic [NUM_W-1:0]   sq_sh;
  logic [NW-1:0]      nb;
  logic [PRICE_W-1:0] mean_r;
  logic [NUM_W-1:0]   dq;
  logic [DR_W-1:0]    drem;
  logic [DEV_W+1:0]   srem;
  logic [DEV_W-1:0]   root;
  logic [SPR_W-1:0]   spread;
  logic               start;

  logic [NW:0]        m_t;
  logic               m_ge;
  logic [NW:0]        m_new;
  logic [DR_W:0]      d_t;
  logic               d_ge;
  logic [DR_W:0]      d_new;
  logic [DEV_W+3:0]   s_t;
  logic [DEV_W+3:0]   s_trial;
  logic               s_ge;
  logic [DEV_W+3:0]   s_new;
  logic [PR_W-1:0]    prod;
  logic [SPR_W:0]     up_sum;

  assign start    = (state == ST_IDLE) && job_valid && !out_full;
  assign job_pop  = start;
  assign out_push = (state == ST_FIN);

  always_comb begin
    // Mean divide: one quotient bit per step.
    m_t   = {mrem, mq[SUM_W-1]};
    m_ge  = (m_t >= {1'b0, n_r});
    m_new = m_ge ? (m_t - {1'b0, n_r}) : m_t;
    // Variance divide by n squared.
    d_t   = {drem, dq[NUM_W-1]};
    d_ge  = (d_t >= {1'b0, nsq_r});
    d_new = d_ge ? (d_t - {1'b0, nsq_r}) : d_t;
    // Square root: two radicand bits per step.
    s_t     = {srem, dq[VAR_W-1 -: 2]};
    s_trial = {2'b00, root, 2'b01};
    s_ge    = (s_t >= s_trial);
    s_new   = s_ge ? (s_t - s_trial) : s_t;
    prod    = PR_W'(k_r) * PR_W'(root);
    up_sum  = (SPR_W+1)'(mean_r) + (SPR_W+1)'(spread);
  end

  always_comb begin
    out_data.middle = mean_r;
    out_data.upper  = (up_sum > (SPR_W+1)'(PRICE_MAX)) ? PRICE_MAX : up_sum[PRICE_W-1:0];
    out_data.lower  = (spread > SPR_W'(mean_r)) ? '0 : (mean_r - spread[PRICE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            cnt   <= CNT_W'(SUM_W);
            state <= ST_PH1;
          end
        end
        ST_PH1: begin
          if (cnt == CNT_W'(1)) begin
            state <= ST_SUB;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_SUB: begin
          cnt   <= CNT_W'(NUM_W);
          state <= ST_PH2;
        end
        ST_PH2: begin
          if (cnt == CNT_W'(1)) begin
            cnt   <= CNT_W'(DEV_W);
            state <= ST_PH3;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_PH3: begin
          if (cnt == CNT_W'(1)) begin
            state <= ST_SPR;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_SPR: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          sum_r <= job_sum;
          n_r   <= job_n;
          nsq_r <= job_nsq;
          k_r   <= job_k;
          mq    <= job_sum;
          mrem  <= '0;
          acc2  <= '0;
          accn  <= '0;
          sq_sh <= NUM_W'(job_sumsq);
          nb    <= job_n;
        end
      end
      ST_PH1: begin
        // The sum is squared MSB first from the same bit that feeds the
        // divider, while n times the square sum runs LSB first.
        mrem  <= m_new[NW-1:0];
        mq    <= {mq[SUM_W-2:0], m_ge};
        acc2  <= {acc2[2*SUM_W-2:0], 1'b0} + (mq[SUM_W-1] ? (2*SUM_W)'(sum_r) : '0);
        accn  <= accn + (nb[0] ? sq_sh : '0);
        sq_sh <= {sq_sh[NUM_W-2:0], 1'b0};
        nb    <= nb >> 1;
      end
      ST_SUB: begin
        mean_r <= mq[PRICE_W-1:0];
        dq     <= accn - NUM_W'(acc2);
        drem   <= '0;
      end
      ST_PH2: begin
        drem <= d_new[DR_W-1:0];
        dq   <= {dq[NUM_W-2:0], d_ge};
        srem <= '0;
        root <= '0;
      end
      ST_PH3: begin
        srem <= s_new[DEV_W+1:0];
        root <= {root[DEV_W-2:0], s_ge};
        dq   <= {dq[NUM_W-3:0], 2'b00};
      end
      ST_SPR: begin
        spread <= prod[PR_W-1:8];
      end
      default: begin
      end
    endcase
  end

  `SWBB_ASSERT_NEXT(a_start_enters_divide, start, state == ST_PH1)
  `SWBB_ASSERT_IMPL(a_result_has_room, state == ST_FIN, !out_full)
  `SWBB_ASSERT_IMPL(a_mean_rem_below_n, state == ST_PH1, mrem < n_r)
  `SWBB_ASSERT_IMPL(a_var_rem_below_nsq, state == ST_PH2, drem < nsq_r)

endmodule

>>> rtl/core/sliding_window_bollinger_bands.sv
// Top level of the sliding-window Bollinger band core: configuration registers,
// front end, job queue, back end and result queue. Depends on swbb_pkg and all core modules.
//
//   channel   direction  handshake            payload
//   input     in         push / full          price, series_start
//   result    out        pop / empty          middle_band, upper_band, lower_band
//   config    in         cfg_write            cfg_index, cfg_data
//
// The front end handles one word at a time: ring read, squares, sum update, queue.
// The back end handles one job at a time through its bit-serial mean divide,
// variance divide and square root.
// Reset is synchronous; it clears the window and the queues and sets the configuration registers to their reset values.
// A full result queue holds the back end, and a full job queue holds the input.
module sliding_window_bollinger_bands import swbb_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [PRICE_W-1:0]     price,
  input  logic                   series_start,
  output logic                   empty,
  input  logic                   pop,
  output logic [PRICE_W-1:0]     middle_band,
  output logic [PRICE_W-1:0]     upper_band,
  output logic [PRICE_W-1:0]     lower_band,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int AW    = $clog2(WINDOW_MAX);
  localparam int NW    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = PRICE_W + AW;
  localparam int SQ_W  = 2 * PRICE_W + AW;
  localparam int JOB_W = SUM_W + SQ_W + NW + 2 * NW + K_W;

  logic [LEN_W-1:0]   window_length;
  logic [K_W-1:0]     band_width_factor;
  logic [NW-1:0]      n_eff;
  logic               len_write;
  logic               front_ready;
  logic               job_push;
  logic               job_full;
  logic               job_empty;
  logic               job_pop;
  logic [SUM_W-1:0]   f_sum;
  logic [SQ_W-1:0]    f_sumsq;
  logic [JOB_W-1:0]   job_in;
  logic [JOB_W-1:0]   job_out;
  logic               out_full;
  logic               out_push;
  result_t            out_data;
  result_t            res_head;

  assign len_write = cfg_write && (cfg_index == REG_WINDOW_LENGTH);

  // A zero length acts as one; a length past the ring size is capped.
  assign n_eff = (window_length == '0) ? NW'(1) :
                 (32'(window_length) > 32'(WINDOW_MAX)) ? NW'(WINDOW_MAX) :
                 NW'(window_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length     <= LEN_RESET;
      band_width_factor <= K_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length     <= cfg_data[LEN_W-1:0];
        REG_BAND_WIDTH:    band_width_factor <= cfg_data[K_W-1:0];
        default: begin
        end
      endcase
    end
  end

  swbb_front #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .n            (n_eff),
    .clear_window (len_write),
    .push         (push),
    .price        (price),
    .series_start (series_start),
    .ready        (front_ready),
    .job_full     (job_full),
    .job_push     (job_push),
    .job_sum      (f_sum),
    .job_sumsq    (f_sumsq)
  );

  assign full   = !front_ready;
  assign job_in = {f_sum, f_sumsq, n_eff, (2*NW)'(n_eff) * (2*NW)'(n_eff), band_width_factor};

  swbb_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  swbb_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!job_empty),
    .job_pop   (job_pop),
    .job_sum   (job_out[JOB_W-1 -: SUM_W]),
    .job_sumsq (job_out[JOB_W-SUM_W-1 -: SQ_W]),
    .job_n     (job_out[3*NW+K_W-1 -: NW]),
    .job_nsq   (job_out[2*NW+K_W-1 -: 2*NW]),
    .job_k     (job_out[K_W-1:0]),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_data)
  );

  swbb_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_data (out_data),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (res_head),
    .empty     (empty)
  );

  assign middle_band = res_head.middle;
  assign upper_band  = res_head.upper;
  assign lower_band  = res_head.lower;

endmodule
